@@ hw/rtl/mbpb_pkg.sv @@
`default_nettype none

package mbpb_pkg;

	// Display geometry and window buffer size.
	localparam int HOR_RES       = 128;
	localparam int VER_RES       = 32;
	localparam int ROWS_PER_PAGE = 8;
	localparam int ROW_SHIFT     = $clog2(ROWS_PER_PAGE);
	localparam int BUF_BYTES     = (HOR_RES * VER_RES) / 8;
	localparam int BUF_AW        = $clog2(BUF_BYTES);

	// Field widths.
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int PAGE_W  = ROW_W - ROW_SHIFT;
	localparam int DATA_W  = 8;
	localparam int WIDTH_W = COL_W + 1;
	localparam int POS_W   = ROW_W + WIDTH_W + 2;
	localparam int BYTE_W  = POS_W - 1 - 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COL_W;

	localparam logic [CFG_IDX_W-1:0] CFG_AREA_LEFT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOP    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_RIGHT  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_BOTTOM = CFG_IDX_W'(3);

	// Request kinds.
	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Access bundle from the sequencer to the window buffer.
	typedef struct packed {
		logic              wr_en;
		logic [BUF_AW-1:0] wr_addr;
		logic [DATA_W-1:0] wr_data;
		logic              rd_en;
		logic [BUF_AW-1:0] rd_addr;
	} buf_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/mbpb_buf.sv @@
`default_nettype none

module mbpb_buf
	import mbpb_pkg::*;
(
	input  wire logic              clk,
	input  wire buf_req_t          req,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [BUF_BYTES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mono_bitmap_to_page_bytes.sv @@
// Channel   Handshake                       Payload
// request   start in, busy out              req_type, store_index, store_data, page, column
// result    done out (one-cycle strobe)     page_byte, starts_page, out_of_window
// config    cfg_valid in, cfg_ready out     cfg_index, cfg_data
//
// A store or an out-of-window read shows its result strobe in the cycle straight after
// the transfer cycle.
// An in-window read runs through the transfer, a step that forms the start position,
// a buffer read for each row of the page that is in the window and in the buffer,
// through the single read port of the window buffer with one shared adder stepping
// the pixel position by the window width, a drain step and the result strobe.
// Reset clears the sequencer and sets the window to the whole display.
// Results are never held off; busy stays high until the result strobe has passed.
`default_nettype none

module mono_bitmap_to_page_bytes
	import mbpb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  req_type,
	input  wire logic [BUF_AW-1:0]     store_index,
	input  wire logic [DATA_W-1:0]     store_data,
	input  wire logic [PAGE_W-1:0]     page,
	input  wire logic [COL_W-1:0]      column,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output logic [DATA_W-1:0]          page_byte,
	output logic                       starts_page,
	output logic                       out_of_window
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_INIT = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [COL_W-1:0]  area_left_q;
	logic [ROW_W-1:0]  area_top_q;
	logic [COL_W-1:0]  area_right_q;
	logic [ROW_W-1:0]  area_bottom_q;

	logic [PAGE_W-1:0]          page_q;
	logic [COL_W-1:0]           col_off_q;
	logic [WIDTH_W-1:0]         width_q;
	logic signed [POS_W-1:0]    pos_q;
	logic [ROW_SHIFT:0]         k_q;
	logic [DATA_W-1:0]          page_byte_q;
	logic                       starts_q;
	logic                       oow_q;

	logic                       pend_vld_s1;
	logic [ROW_SHIFT-1:0]       pend_k_s1;
	logic [2:0]                 pend_bit_s1;

	logic                       accept;
	logic                       win_bad;
	logic signed [ROW_W:0]      row_diff;
	logic signed [WIDTH_W:0]    width_s;
	logic signed [POS_W-1:0]    base_prod;
	logic signed [POS_W-1:0]    pos_init;
	logic signed [POS_W-1:0]    pos_next;
	logic [ROW_W-1:0]           row_cur;
	logic                       row_hit;
	logic                       byte_ok;
	logic                       issue_hit;
	logic [DATA_W-1:0]          rd_data;
	buf_req_t                   buf_req;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign done          = (state_q == ST_DONE);
	assign page_byte     = page_byte_q;
	assign starts_page   = starts_q;
	assign out_of_window = oow_q;

	// The page range of the window is its first and last row divided by eight.
	assign win_bad = (area_right_q < area_left_q) || (area_bottom_q < area_top_q) ||
		(column < area_left_q) || (column > area_right_q) ||
		(page < area_top_q[ROW_W-1:ROW_SHIFT]) ||
		(page > area_bottom_q[ROW_W-1:ROW_SHIFT]);

	// Position of the page's top row relative to the window; negative above the window.
	assign row_diff  = $signed({1'b0, page_q, {ROW_SHIFT{1'b0}}}) -
		$signed({1'b0, area_top_q});
	assign width_s   = $signed({1'b0, width_q});
	assign base_prod = POS_W'(row_diff) * POS_W'(width_s);
	assign pos_init  = base_prod + $signed({{(POS_W-COL_W){1'b0}}, col_off_q});
	assign pos_next  = pos_q + $signed({{(POS_W-WIDTH_W){1'b0}}, width_q});

	assign row_cur   = {page_q, k_q[ROW_SHIFT-1:0]};
	assign row_hit   = (row_cur >= area_top_q) && (row_cur <= area_bottom_q);
	assign byte_ok   = (pos_q[POS_W-2:3] < BYTE_W'(BUF_BYTES));
	assign issue_hit = (state_q == ST_RUN) && !k_q[ROW_SHIFT] && row_hit && byte_ok;

	always_comb begin
		buf_req         = '0;
		buf_req.wr_en   = accept && (req_type == REQ_STORE) &&
			({1'b0, store_index} < (BUF_AW+1)'(BUF_BYTES));
		buf_req.wr_addr = store_index;
		buf_req.wr_data = store_data;
		buf_req.rd_en   = issue_hit;
		buf_req.rd_addr = pos_q[3 +: BUF_AW];
	end

	mbpb_buf u_buf (
		.clk     (clk),
		.req     (buf_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_left_q   <= '0;
			area_top_q    <= '0;
			area_right_q  <= COL_W'(HOR_RES - 1);
			area_bottom_q <= ROW_W'(VER_RES - 1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_AREA_LEFT: begin
					area_left_q <= cfg_data;
				end
				CFG_AREA_TOP: begin
					area_top_q <= cfg_data[ROW_W-1:0];
				end
				CFG_AREA_RIGHT: begin
					area_right_q <= cfg_data;
				end
				CFG_AREA_BOTTOM: begin
					area_bottom_q <= cfg_data[ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			pend_vld_s1 <= 1'b0;
		end else begin
			pend_vld_s1 <= issue_hit;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_READ && !win_bad) begin
							state_q <= ST_INIT;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_INIT: begin
					k_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (!k_q[ROW_SHIFT]) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q      <= page;
			col_off_q   <= column - area_left_q;
			width_q     <= {1'b0, area_right_q} - {1'b0, area_left_q} + 1'b1;
			page_byte_q <= '0;
			oow_q       <= (req_type == REQ_READ) && win_bad;
			starts_q    <= (req_type == REQ_READ) && !win_bad && (column == area_left_q);
		end else if (pend_vld_s1) begin
			page_byte_q[pend_k_s1] <= rd_data[pend_bit_s1];
		end
		if (state_q == ST_INIT) begin
			pos_q <= pos_init;
		end else if (state_q == ST_RUN && !k_q[ROW_SHIFT]) begin
			pos_q <= pos_next;
		end
		pend_k_s1   <= k_q[ROW_SHIFT-1:0];
		pend_bit_s1 <= pos_q[2:0];
	end

	// The strobe lasts one cycle and the block is free straight after it.
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe not followed by idle");

	a_oow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_window |-> page_byte == '0 && !starts_page)
		else $error("out-of-window result carries data");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("transfer accepted without going busy");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		buf_req.wr_en |-> !busy && !buf_req.rd_en)
		else $error("buffer written while a request is in progress");

	a_capture_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_s1 |-> state_q == ST_RUN)
		else $error("pixel captured outside the gather phase");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

module tb_top;
	import mbpb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 100;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_AREA_BOTTOM + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED = '1;

	typedef struct packed {
		logic              req;
		logic [BUF_AW-1:0] idx;
		logic [DATA_W-1:0] data;
		logic [PAGE_W-1:0] pg;
		logic [COL_W-1:0]  col;
	} page_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] pbyte;
		logic              starts;
		logic              oow;
	} page_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		page_req_t              rq;
		logic [CFG_IDX_W-1:0]   reg_id;
		logic [CFG_DATA_W-1:0]  reg_val;
		logic                   typed;
		page_result_t           want;
	} stim_row_t;

	localparam page_result_t ZERO_RESULT = '{8'h00, 1'b0, 1'b0};
	localparam page_result_t OUTSIDE     = '{8'h00, 1'b0, 1'b1};

	// Directed rows. Results are typed in for stores and out-of-window reads only.
	localparam stim_row_t DIRECTED [32] = '{
		'{ROW_ITEM, '{REQ_STORE, 9'd0,   8'hFF, 2'd0, 7'd0},   CFG_AREA_LEFT, 7'd0, 1'b1, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_STORE, 9'd511, 8'h00, 2'd3, 7'd127}, CFG_AREA_LEFT, 7'd0, 1'b1, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_STORE, 9'd170, 8'h5A, 2'd1, 7'd85},  CFG_AREA_LEFT, 7'd0, 1'b1, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd0, 7'd0},   CFG_AREA_LEFT, 7'd0, 1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd511, 8'hFF, 2'd3, 7'd127}, CFG_AREA_LEFT, 7'd0, 1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd85,  8'hA5, 2'd1, 7'd85},  CFG_AREA_LEFT, 7'd0, 1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_LEFT,   7'd10,  1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_RIGHT,  7'd20,  1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_TOP,    7'h65,  1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_BOTTOM, 7'd12,  1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd0, 7'd10},  CFG_AREA_LEFT, 7'd0, 1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd1, 7'd20},  CFG_AREA_LEFT, 7'd0, 1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd0, 7'd9},   CFG_AREA_LEFT, 7'd0, 1'b1, OUTSIDE},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd1, 7'd21},  CFG_AREA_LEFT, 7'd0, 1'b1, OUTSIDE},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd2, 7'd15},  CFG_AREA_LEFT, 7'd0, 1'b1, OUTSIDE},
		'{ROW_ITEM, '{REQ_STORE, 9'd3,   8'h81, 2'd2, 7'd15},  CFG_AREA_LEFT, 7'd0, 1'b1, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd3,   8'h00, 2'd1, 7'd15},  CFG_AREA_LEFT, 7'd0, 1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_TOP,    7'd17,  1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd1, 7'd15},  CFG_AREA_LEFT, 7'd0, 1'b1, OUTSIDE},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd2, 7'd15},  CFG_AREA_LEFT, 7'd0, 1'b1, OUTSIDE},
		'{ROW_CFG,  '0, CFG_LAST_UNUSED, 7'h7F,  1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_TOP,    7'd0,   1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_LEFT,   7'd100, 1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_RIGHT,  7'd50,  1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd0, 7'd60},  CFG_AREA_LEFT, 7'd0, 1'b1, OUTSIDE},
		'{ROW_CFG,  '0, CFG_AREA_LEFT,   7'd127, 1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_RIGHT,  7'd127, 1'b0, ZERO_RESULT},
		'{ROW_CFG,  '0, CFG_AREA_BOTTOM, 7'd31,  1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd3, 7'd127}, CFG_AREA_LEFT, 7'd0, 1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd0, 7'd126}, CFG_AREA_LEFT, 7'd0, 1'b1, OUTSIDE},
		'{ROW_CFG,  '0, CFG_AREA_LEFT,   7'd0,   1'b0, ZERO_RESULT},
		'{ROW_ITEM, '{REQ_READ,  9'd0,   8'h00, 2'd2, 7'd0},   CFG_AREA_LEFT, 7'd0, 1'b0, ZERO_RESULT}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  req_type = REQ_STORE;
	logic [BUF_AW-1:0]     store_index = '0;
	logic [DATA_W-1:0]     store_data = '0;
	logic [PAGE_W-1:0]     page = '0;
	logic [COL_W-1:0]      column = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_AREA_LEFT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic [DATA_W-1:0]     page_byte;
	logic                  starts_page;
	logic                  out_of_window;

	// Predictor state: the window buffer image and the window registers.
	logic [DATA_W-1:0] pixel_mem [BUF_BYTES];
	logic [COL_W-1:0]  win_left = '0;
	logic [ROW_W-1:0]  win_top = '0;
	logic [COL_W-1:0]  win_right = COL_W'(HOR_RES - 1);
	logic [ROW_W-1:0]  win_bottom = ROW_W'(VER_RES - 1);

	page_result_t expected_results [$];

	bit start_high = 1'b0;
	bit cfg_high = 1'b0;
	bit idle_ok = 1'b1;
	int errors = 0;
	int quiet_cycles = 0;
	int n_stores = 0;
	int n_reads_in = 0;
	int n_first_col = 0;
	int n_reads_out = 0;
	int n_cfg = 0;
	int n_results = 0;

	mono_bitmap_to_page_bytes DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.store_index(store_index),
		.store_data(store_data),
		.page(page),
		.column(column),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.page_byte(page_byte),
		.starts_page(starts_page),
		.out_of_window(out_of_window)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic page_result_t predict_page_result(input page_req_t r);
		page_result_t res;
		int unsigned width;
		int unsigned row;
		int unsigned pos;
		res = '0;
		if (r.req == REQ_STORE) begin
			pixel_mem[r.idx] = r.data;
			return res;
		end
		if (win_right < win_left || win_bottom < win_top || r.col < win_left ||
				r.col > win_right || r.pg < win_top / ROWS_PER_PAGE ||
				r.pg > win_bottom / ROWS_PER_PAGE) begin
			res.oow = 1'b1;
			return res;
		end
		width = int'(win_right) - int'(win_left) + 1;
		for (int k = 0; k < ROWS_PER_PAGE; k++) begin
			row = r.pg * ROWS_PER_PAGE + k;
			if (row >= win_top && row <= win_bottom) begin
				pos = (row - win_top) * width + (r.col - win_left);
				if ((pos >> 3) < BUF_BYTES)
					res.pbyte[k] = pixel_mem[pos >> 3][pos & 7];
			end
		end
		res.starts = (r.col == win_left);
		return res;
	endfunction

	// Holds start high across back-to-back transfers; lowers it only for an idle gap.
	task automatic issue_request(input page_req_t r, input bit typed, input page_result_t want);
		page_result_t res;
		if (idle_ok && $urandom_range(0, 99) < 10) begin
			if (start_high) begin
				start <= 1'b0;
				start_high = 1'b0;
			end
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_type <= r.req;
		store_index <= r.idx;
		store_data <= r.data;
		page <= r.pg;
		column <= r.col;
		start <= 1'b1;
		start_high = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		res = predict_page_result(r);
		expected_results.push_back(typed ? want : res);
		if (r.req == REQ_STORE)
			n_stores++;
		else if (res.oow)
			n_reads_out++;
		else begin
			n_reads_in++;
			if (res.starts)
				n_first_col++;
		end
	endtask

	task automatic drain_results();
		if (start_high) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
		while (expected_results.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] id,
			input logic [CFG_DATA_W-1:0] val);
		cfg_index <= id;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		cfg_high = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (id)
			CFG_AREA_LEFT: win_left = val;
			CFG_AREA_TOP: win_top = val[ROW_W-1:0];
			CFG_AREA_RIGHT: win_right = val;
			CFG_AREA_BOTTOM: win_bottom = val[ROW_W-1:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic end_config();
		if (cfg_high) begin
			cfg_valid <= 1'b0;
			cfg_high = 1'b0;
		end
	endtask

	always @(posedge clk) begin : result_check
		page_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			n_results++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result page_byte %h starts_page %b out_of_window %b",
					$time, page_byte, starts_page, out_of_window);
			end else begin
				want = expected_results.pop_front();
				if (page_byte !== want.pbyte) begin
					errors++;
					$display("%0t: page_byte expected %h actual %h", $time, want.pbyte, page_byte);
				end
				if (starts_page !== want.starts) begin
					errors++;
					$display("%0t: starts_page expected %b actual %b",
						$time, want.starts, starts_page);
				end
				if (out_of_window !== want.oow) begin
					errors++;
					$display("%0t: out_of_window expected %b actual %b",
						$time, want.oow, out_of_window);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1)
			quiet_cycles <= 0;
		else if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("%0t: no transfer for %0d cycles, %0d results outstanding",
			$time, STALL_LIMIT, expected_results.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		page_req_t r;
		logic [COL_W-1:0] l;
		logic [COL_W-1:0] rgt;
		logic [ROW_W-1:0] t;
		logic [ROW_W-1:0] b;
		logic [CFG_DATA_W-1:0] val;
		logic [CFG_IDX_W-1:0] reg_order [4];
		int first;
		int roll;

		reg_order = '{CFG_AREA_LEFT, CFG_AREA_TOP, CFG_AREA_RIGHT, CFG_AREA_BOTTOM};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The buffer has no defined contents after reset, so fill every byte first.
		for (int i = 0; i < BUF_BYTES; i++) begin
			r.req = REQ_STORE;
			r.idx = BUF_AW'(i);
			r.data = DATA_W'($urandom);
			r.pg = PAGE_W'($urandom);
			r.col = COL_W'($urandom);
			issue_request(r, 1'b0, ZERO_RESULT);
		end

		for (int n = 0; n < $size(DIRECTED); n++) begin
			if (DIRECTED[n].kind == ROW_CFG) begin
				drain_results();
				write_register(DIRECTED[n].reg_id, DIRECTED[n].reg_val);
			end else begin
				end_config();
				issue_request(DIRECTED[n].rq, DIRECTED[n].typed, DIRECTED[n].want);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			l = COL_W'($urandom);
			rgt = COL_W'($urandom_range(l, HOR_RES - 1));
			t = ROW_W'($urandom);
			b = ROW_W'($urandom_range(t, VER_RES - 1));
			case (ph)
				0: begin
					l = '0;
					rgt = COL_W'(HOR_RES - 1);
					t = '0;
					b = ROW_W'(VER_RES - 1);
				end
				1: begin
					l = COL_W'(HOR_RES - 1);
					rgt = l;
					t = ROW_W'(VER_RES - 1);
					b = t;
				end
				2: begin
					l = '0;
					rgt = '0;
					t = '0;
					b = '0;
				end
				3: begin
					l = COL_W'($urandom_range(1, HOR_RES - 1));
					rgt = COL_W'($urandom_range(0, l - 1));
				end
				4: begin
					t = ROW_W'($urandom_range(1, VER_RES - 1));
					b = ROW_W'($urandom_range(0, t - 1));
				end
				default: ;
			endcase
			// Register order is rotated so that each one is sometimes written last.
			first = $urandom_range(0, 3);
			for (int k = 0; k < 4; k++) begin
				case (reg_order[(first + k) % 4])
					CFG_AREA_LEFT: val = l;
					CFG_AREA_RIGHT: val = rgt;
					CFG_AREA_TOP: val = {2'($urandom), t};
					default: val = {2'($urandom), b};
				endcase
				write_register(reg_order[(first + k) % 4], val);
			end
			if ($urandom_range(0, 2) == 0)
				write_register(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
					CFG_DATA_W'($urandom));
			end_config();

			// A few phases run with no idle gaps at all.
			idle_ok = !(ph >= 5 && ph <= 7);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				roll = $urandom_range(0, 99);
				r.req = (roll < 30) ? REQ_STORE : REQ_READ;
				r.idx = BUF_AW'($urandom);
				r.data = DATA_W'($urandom);
				r.pg = PAGE_W'($urandom);
				r.col = COL_W'($urandom);
				if (r.req == REQ_READ && roll < 85 && win_right >= win_left &&
						win_bottom >= win_top) begin
					r.col = (roll < 40) ? win_left :
						COL_W'($urandom_range(win_left, win_right));
					r.pg = PAGE_W'($urandom_range(win_top / ROWS_PER_PAGE,
						win_bottom / ROWS_PER_PAGE));
				end
				issue_request(r, 1'b0, ZERO_RESULT);
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		$display("Run covered %0d stores, %0d in-window reads (%0d on the first column),",
			n_stores, n_reads_in, n_first_col);
		$display("%0d out-of-window reads and %0d register writes; %0d results checked.",
			n_reads_out, n_cfg, n_results);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
